/* hdl/bwr_pkg.sv */
`timescale 1ns / 1ps
package bwr_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Field widths
  localparam int COORD_W  = 8;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int DIM_W    = 9;
  localparam int RADIUS_W = 7;

  // Datapath widths: offsets are signed COORD_W+1, squared sum, root, scaled offset
  localparam int OFS_W   = COORD_W + 1;
  localparam int SUM_W   = 2 * OFS_W - 1;
  localparam int ROOT_W  = OFS_W;
  localparam int RIDX_W  = $clog2(ROOT_W);
  localparam int PROD_W  = COORD_W + RADIUS_W;
  localparam int STEP_W  = $clog2(PROD_W);
  localparam int PLACE_W = PROD_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_RADIUS = 3'd4;

  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT  = 9'd256;
  localparam logic [COORD_W-1:0]  RST_CENTER_X      = 8'd128;
  localparam logic [COORD_W-1:0]  RST_CENTER_Y      = 8'd128;
  localparam logic [RADIUS_W-1:0] RST_EFFECT_RADIUS = 7'd72;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

/* hdl/bwr_ifs.sv */
`timescale 1ns / 1ps
interface bwr_req_if;
  import bwr_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] pix_x;
  logic [COORD_W-1:0] pix_y;
  logic [CHAN_W-1:0]  in_chan0;
  logic [CHAN_W-1:0]  in_chan1;
  logic [CHAN_W-1:0]  in_chan2;
  modport source(output valid, req_type, pix_x, pix_y, in_chan0, in_chan1, in_chan2,
                 input ready);
  modport sink(input valid, req_type, pix_x, pix_y, in_chan0, in_chan1, in_chan2,
               output ready);
endinterface

interface bwr_pix_if;
  import bwr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_chan0;
  logic [CHAN_W-1:0] out_chan1;
  logic [CHAN_W-1:0] out_chan2;
  logic [CHAN_W-1:0] out_alpha;
  modport source(output valid, out_chan0, out_chan1, out_chan2, out_alpha, input ready);
  modport sink(input valid, out_chan0, out_chan1, out_chan2, out_alpha, output ready);
endinterface

interface bwr_cfg_if;
  import bwr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/bulge_warp_remap.sv */
`timescale 1ns / 1ps
// Bulge (magnify) warp over a stored three-channel frame.
//
// req  : request channel. A write request (req_type = REQ_WRITE) stores one
//        pixel at (pix_x, pix_y); writes outside the active frame are dropped.
//        A read request returns the warped pixel at (pix_x, pix_y) on rsp.
// rsp  : one response per read request, out_alpha always 255. A read outside
//        the frame returns zero color.
// cfg  : register writes (width, height, center, radius); always ready, and
//        only to be used while no read request is in flight.
// A write request is stored as it is taken and leaves req.ready high. A read
// inside the radius holds req.ready low through its steps: square, bit-serial
// square root (one root bit per cycle through a single 9x9 multiplier), scale
// multiply, the two restoring dividers (one quotient bit per cycle), place and
// clamp the source, frame memory read, and load of the response register.
// A read at or past the radius skips the scale multiply, divide and place; a
// read outside the frame goes straight to the memory read.
// The response register parts the two sides: the next request is taken while
// a response waits; a finished read holds until that register frees up.
// Reset clears control and configuration; frame contents stay undefined.
module bulge_warp_remap (
  input logic      clk,
  input logic      rst,
  bwr_req_if.sink  req,
  bwr_pix_if.source rsp,
  bwr_cfg_if.sink  cfg
);
  import bwr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQUARE, ST_ROOT, ST_SCALE, ST_DIVIDE, ST_PLACE, ST_FETCH, ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic [COORD_W-1:0]  center_x;
  logic [COORD_W-1:0]  center_y;
  logic [RADIUS_W-1:0] effect_radius;

  // Read datapath
  logic                     rd_inside;
  logic signed [OFS_W-1:0]  dx;
  logic signed [OFS_W-1:0]  dy;
  logic [SUM_W-1:0]         sq_sum;
  logic [ROOT_W-1:0]        root;
  logic [RIDX_W-1:0]        bit_idx;
  logic [STEP_W-1:0]        step;
  logic [PROD_W-1:0]        num_x;
  logic [PROD_W-1:0]        num_y;
  logic [RADIUS_W:0]        rem_x;
  logic [RADIUS_W:0]        rem_y;
  logic                     neg_x;
  logic                     neg_y;
  logic [COORD_W-1:0]       src_x;
  logic [COORD_W-1:0]       src_y;
  logic [PIX_W-1:0]         mem [MAX_WIDTH * MAX_HEIGHT];
  logic [PIX_W-1:0]         rd_data;

  // Response register
  logic              out_valid;
  logic [CHAN_W-1:0] out_chan0;
  logic [CHAN_W-1:0] out_chan1;
  logic [CHAN_W-1:0] out_chan2;
  logic              rsp_load;

  // Active frame is clipped to the store
  logic [DIM_W-1:0] frame_w;
  logic [DIM_W-1:0] frame_h;
  logic             req_inside;
  logic             req_take;
  logic             mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign frame_w = (int'(image_width) < MAX_WIDTH) ? image_width : DIM_W'(MAX_WIDTH);
  assign frame_h = (int'(image_height) < MAX_HEIGHT) ? image_height : DIM_W'(MAX_HEIGHT);
  assign req_inside = (DIM_W'(req.pix_x) < frame_w) && (DIM_W'(req.pix_y) < frame_h);
  assign req.ready  = (state == ST_IDLE);
  assign req_take   = req.valid && req.ready;
  assign mem_we     = req_take && (req.req_type == REQ_WRITE) && req_inside;
  assign wr_addr    = ADDR_W'(req.pix_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req.pix_x);
  assign rd_addr    = ADDR_W'(src_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(src_x);

  // Load the response register once the read is done and the slot is free
  assign rsp_load   = (state == ST_DONE) && (!out_valid || rsp.ready);

  // Square root: try one root bit per cycle, highest first
  logic [ROOT_W-1:0]   root_cand;
  logic [2*ROOT_W-1:0] cand_sq;
  assign root_cand = root | (ROOT_W'(1) << bit_idx);
  assign cand_sq   = (2*ROOT_W)'(root_cand) * (2*ROOT_W)'(root_cand);

  // Offset magnitudes for the scale multiply
  logic [COORD_W-1:0] mag_x;
  logic [COORD_W-1:0] mag_y;
  assign mag_x = dx[OFS_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
  assign mag_y = dy[OFS_W-1] ? COORD_W'(-dy) : COORD_W'(dy);

  // Restoring divide step, both lanes share the divisor
  logic [RADIUS_W:0] shx;
  logic [RADIUS_W:0] shy;
  logic              fit_x;
  logic              fit_y;
  assign shx   = {rem_x[RADIUS_W-1:0], num_x[PROD_W-1]};
  assign shy   = {rem_y[RADIUS_W-1:0], num_y[PROD_W-1]};
  assign fit_x = shx >= {1'b0, effect_radius};
  assign fit_y = shy >= {1'b0, effect_radius};

  // Add signed offset to the centre and clamp to [0, lim-1]
  function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] c,
                                               input logic [PROD_W-1:0] q,
                                               input logic neg,
                                               input logic [DIM_W-1:0] lim);
    logic signed [PLACE_W-1:0] v;
    logic signed [PLACE_W-1:0] top;
    v   = $signed(PLACE_W'(c)) + (neg ? -$signed(PLACE_W'(q)) : $signed(PLACE_W'(q)));
    top = $signed(PLACE_W'(lim)) - $signed(PLACE_W'(1));
    if (v < 0) begin
      return '0;
    end else if (v > top) begin
      return COORD_W'(top);
    end
    return COORD_W'(v);
  endfunction

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      center_x      <= RST_CENTER_X;
      center_y      <= RST_CENTER_Y;
      effect_radius <= RST_EFFECT_RADIUS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:   image_width   <= cfg.data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg.data;
        REG_CENTER_X:      center_x      <= cfg.data[COORD_W-1:0];
        REG_CENTER_Y:      center_y      <= cfg.data[COORD_W-1:0];
        REG_EFFECT_RADIUS: effect_radius <= cfg.data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame store: one write port from the request side, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {req.in_chan2, req.in_chan1, req.in_chan0};
    end
    if (state == ST_FETCH) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Read sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a finished read, else drop the response once taken
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take && (req.req_type == REQ_READ)) begin
            rd_inside <= req_inside;
            src_x     <= req.pix_x;
            src_y     <= req.pix_y;
            dx        <= $signed({1'b0, req.pix_x}) - $signed({1'b0, center_x});
            dy        <= $signed({1'b0, req.pix_y}) - $signed({1'b0, center_y});
            state     <= req_inside ? ST_SQUARE : ST_FETCH;
          end
        end
        ST_SQUARE: begin
          sq_sum  <= SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
          root    <= '0;
          bit_idx <= RIDX_W'(ROOT_W - 1);
          state   <= ST_ROOT;
        end
        ST_ROOT: begin
          if (cand_sq <= (2*ROOT_W)'(sq_sum)) begin
            root <= root_cand;
          end
          if (bit_idx == '0) begin
            state <= ST_SCALE;
          end else begin
            bit_idx <= bit_idx - RIDX_W'(1);
          end
        end
        ST_SCALE: begin
          // outside the radius the pixel passes unchanged
          if (root < ROOT_W'(effect_radius)) begin
            num_x <= PROD_W'(mag_x) * PROD_W'(root[RADIUS_W-1:0]);
            num_y <= PROD_W'(mag_y) * PROD_W'(root[RADIUS_W-1:0]);
            neg_x <= dx[OFS_W-1];
            neg_y <= dy[OFS_W-1];
            rem_x <= '0;
            rem_y <= '0;
            step  <= '0;
            state <= ST_DIVIDE;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_DIVIDE: begin
          rem_x <= fit_x ? shx - {1'b0, effect_radius} : shx;
          rem_y <= fit_y ? shy - {1'b0, effect_radius} : shy;
          num_x <= {num_x[PROD_W-2:0], fit_x};
          num_y <= {num_y[PROD_W-2:0], fit_y};
          if (step == STEP_W'(PROD_W - 1)) begin
            state <= ST_PLACE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_PLACE: begin
          src_x <= place(center_x, num_x, neg_x, frame_w);
          src_y <= place(center_y, num_y, neg_y, frame_h);
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the response register is free
          if (rsp_load) begin
            out_chan0 <= rd_inside ? rd_data[CHAN_W-1:0] : '0;
            out_chan1 <= rd_inside ? rd_data[2*CHAN_W-1:CHAN_W] : '0;
            out_chan2 <= rd_inside ? rd_data[3*CHAN_W-1:2*CHAN_W] : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_chan0 = out_chan0;
  assign rsp.out_chan1 = out_chan1;
  assign rsp.out_chan2 = out_chan2;
  assign rsp.out_alpha = ALPHA_OPAQUE;

  // The root found is the floor square root of the squared distance
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE) |->
      ((2*ROOT_W)'(root) * (2*ROOT_W)'(root) <= (2*ROOT_W)'(sq_sum)) &&
      (((2*ROOT_W)'(root) + 1) * ((2*ROOT_W)'(root) + 1) > (2*ROOT_W)'(sq_sum)))
    else $error("square root out of range");

  // Divider remainders end below the radius
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |-> (rem_x < {1'b0, effect_radius}) &&
                            (rem_y < {1'b0, effect_radius}))
    else $error("divider remainder not reduced");

  // No store write can collide with the read fetch
  a_no_wr_on_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> !mem_we)
    else $error("frame write during fetch");

  // A response appears only when a finished read loads it
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("response without a finished read");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  import bwr_pkg::*;

  // Cycles to let pass after the last response before touching the
  // registers or ending the run.
  localparam int HOLD_OFF = 40;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 60;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] c2;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c0;
  } warped_pix_t;

  // Directed plan: register writes, pixel stores, fetches checked against the
  // predictor, and fetches whose answer is typed in.
  typedef enum logic [1:0] {ROW_REG, ROW_STORE, ROW_FETCH, ROW_FETCH_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          a;
    int          b;
    logic [23:0] pix;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  bwr_req_if req_bus ();
  bwr_pix_if rsp_bus ();
  bwr_cfg_if cfg_bus ();

  bulge_warp_remap uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers, frame contents and which entries hold data.
  logic [DIM_W-1:0]    act_w  = RST_IMAGE_WIDTH;
  logic [DIM_W-1:0]    act_h  = RST_IMAGE_HEIGHT;
  logic [COORD_W-1:0]  act_cx = RST_CENTER_X;
  logic [COORD_W-1:0]  act_cy = RST_CENTER_Y;
  logic [RADIUS_W-1:0] act_r  = RST_EFFECT_RADIUS;
  bit [PIX_W-1:0]      frame_shadow [MAX_WIDTH*MAX_HEIGHT];
  bit                  frame_known  [MAX_WIDTH*MAX_HEIGHT];

  warped_pix_t warped_q [$];
  plan_row_t   plan [$];

  int  n_err = 0;
  int  idle_cycles = 0;
  bit  busy = 1'b0;         // a request went in since the last register write
  bit  req_no_idle = 1'b0;  // stretches with back-to-back requests
  bit  rsp_no_idle = 1'b0;  // stretches with the response side always ready

  task automatic report_mismatch(input string what);
    if (n_err < MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $time, what);
    n_err++;
  endtask

  function automatic int draw_gap(input bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int root_floor(input int v);
    int root, t;
    root = 0;
    for (int b = 8; b >= 0; b--) begin
      t = root | (1 << b);
      if (t * t <= v)
        root = t;
    end
    return root;
  endfunction

  function automatic int clamp_to(input int v, input int lim);
    if (v < 0)
      return 0;
    if (v > lim - 1)
      return lim - 1;
    return v;
  endfunction

  // Work out where a read at (x,y) takes its pixel from. Returns 0 when
  // (x,y) lies outside the active frame.
  function automatic bit warp_source(input int x, input int y, output int sx, output int sy);
    int w, h, dx, dy, dis, r;
    w = (int'(act_w) < MAX_WIDTH) ? int'(act_w) : MAX_WIDTH;
    h = (int'(act_h) < MAX_HEIGHT) ? int'(act_h) : MAX_HEIGHT;
    sx = x;
    sy = y;
    if (x >= w || y >= h)
      return 1'b0;
    dx = x - int'(act_cx);
    dy = y - int'(act_cy);
    dis = root_floor(dx * dx + dy * dy);
    r = int'(act_r);
    // Zero radius never passes this test, so the pixel stays put.
    if (dis < r) begin
      sx = clamp_to(dx * dis / r + int'(act_cx), w);
      sy = clamp_to(dy * dis / r + int'(act_cy), h);
    end
    return 1'b1;
  endfunction

  function automatic warped_pix_t as_warped(input logic [PIX_W-1:0] p);
    return '{alpha: ALPHA_OPAQUE, c2: p[23:16], c1: p[15:8], c0: p[7:0]};
  endfunction

  function automatic void add_row(input row_kind_t k, input int a, input int b,
                                  input logic [23:0] pix = 24'h0);
    plan.push_back('{kind: k, a: a, b: b, pix: pix});
  endfunction

  // Present one request, wait for it to be taken, then update the shadow.
  // Valid stays high after the handshake; the next call lowers it when it waits out a gap, and drain lowers it.
  task automatic send_request(input logic kind, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix,
                              input bit known);
    int gap, sx, sy;
    logic [PIX_W-1:0] drive_pix;
    gap = draw_gap(req_no_idle);
    drive_pix = (kind == REQ_READ) ? PIX_W'($urandom) : pix;
    cfg_bus.valid <= 1'b0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.pix_x    <= x;
    req_bus.pix_y    <= y;
    req_bus.in_chan0 <= drive_pix[7:0];
    req_bus.in_chan1 <= drive_pix[15:8];
    req_bus.in_chan2 <= drive_pix[23:16];
    do @(posedge clk); while (!req_bus.ready);
    busy = 1'b1;
    if (kind == REQ_WRITE) begin
      // Writes outside the frame are dropped.
      if (warp_source(x, y, sx, sy)) begin
        frame_shadow[int'(y) * MAX_WIDTH + int'(x)] = pix;
        frame_known[int'(y) * MAX_WIDTH + int'(x)] = 1'b1;
      end
    end else if (known) begin
      warped_q.push_back(as_warped(pix));
    end else if (warp_source(x, y, sx, sy)) begin
      warped_q.push_back(as_warped(frame_shadow[sy * MAX_WIDTH + sx]));
    end else begin
      warped_q.push_back(as_warped('0));
    end
  endtask

  // Store a pixel at the source of a coming read if that entry never got one,
  // so no read touches undefined frame contents.
  task automatic fill_source(input int x, input int y);
    int sx, sy;
    if (warp_source(x, y, sx, sy) && !frame_known[sy * MAX_WIDTH + sx])
      send_request(REQ_WRITE, sx[7:0], sy[7:0], PIX_W'($urandom), 1'b0);
  endtask

  task automatic fetch(input int x, input int y);
    fill_source(x, y);
    send_request(REQ_READ, x[7:0], y[7:0], '0, 1'b0);
  endtask

  // Bring the block to rest: all responses in, then the hold-off.
  task automatic drain_block();
    if (busy) begin
      req_bus.valid <= 1'b0;
      while (warped_q.size() != 0) @(posedge clk);
      repeat (HOLD_OFF) @(posedge clk);
      busy = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_IMAGE_WIDTH:   act_w  = val;
      REG_IMAGE_HEIGHT:  act_h  = val;
      REG_CENTER_X:      act_cx = val[COORD_W-1:0];
      REG_CENTER_Y:      act_cy = val[COORD_W-1:0];
      REG_EFFECT_RADIUS: act_r  = val[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  // Half the time inside the frame, often near the centre, sometimes anywhere.
  function automatic int pick_coord(input int lim, input int centre, input int rad);
    int sel, off, v;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      v = $urandom_range(0, lim - 1);
    end else if (sel < 8) begin
      off = $urandom_range(0, 2 * rad + 1);
      v = centre + off - rad;
    end else begin
      v = $urandom_range(0, 255);
    end
    return clamp_to(v, 256);
  endfunction

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7)
      return $urandom_range(1, 32);
    if (sel < 9)
      return $urandom_range(33, 256);
    return 256;
  endfunction

  function automatic int pick_radius(input int w, input int h);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5)
      return root_floor(w * w + h * h) / 5;
    if (sel < 7)
      return $urandom_range(0, 72);
    if (sel < 8)
      return 0;
    return 72;
  endfunction

  // Hang detector: count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Response side: stall a random while, then take one response and check it.
  initial begin : pixel_sink
    int stall;
    warped_pix_t got, want;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(rsp_no_idle);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      got = '{alpha: rsp_bus.out_alpha, c2: rsp_bus.out_chan2, c1: rsp_bus.out_chan1,
              c0: rsp_bus.out_chan0};
      if (warped_q.size() == 0) begin
        report_mismatch($sformatf("response %h with no read request pending", got));
      end else begin
        want = warped_q.pop_front();
        if (got.c0 !== want.c0)
          report_mismatch($sformatf("out_chan0 got %h want %h", got.c0, want.c0));
        if (got.c1 !== want.c1)
          report_mismatch($sformatf("out_chan1 got %h want %h", got.c1, want.c1));
        if (got.c2 !== want.c2)
          report_mismatch($sformatf("out_chan2 got %h want %h", got.c2, want.c2));
        if (got.alpha !== want.alpha)
          report_mismatch($sformatf("out_alpha got %h want %h", got.alpha, want.alpha));
      end
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_WRITE;
    req_bus.pix_x    <= '0;
    req_bus.pix_y    <= '0;
    req_bus.in_chan0 <= '0;
    req_bus.in_chan1 <= '0;
    req_bus.in_chan2 <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_IMAGE_WIDTH;
    cfg_bus.data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full frame, centre (128,128), radius 72.
    add_row(ROW_STORE, 0, 0, 24'hFFFFFF);
    add_row(ROW_FETCH_KNOWN, 0, 0, 24'hFFFFFF);       // far corner, outside the bulge
    add_row(ROW_STORE, 255, 255, 24'h000000);
    add_row(ROW_FETCH_KNOWN, 255, 255, 24'h000000);
    add_row(ROW_STORE, 128, 128, 24'h5AC3A5);
    add_row(ROW_FETCH_KNOWN, 128, 128, 24'h5AC3A5);   // the centre maps to itself
    add_row(ROW_STORE, 118, 128, 24'h123456);
    add_row(ROW_FETCH, 100, 128);                     // negative offset, truncated toward zero
    add_row(ROW_FETCH, 130, 128);
    add_row(ROW_FETCH, 140, 150);
    // Small frame, radius as pick_radius works it out from the diagonal.
    add_row(ROW_REG, REG_IMAGE_WIDTH, 16);
    add_row(ROW_REG, REG_IMAGE_HEIGHT, 8);
    add_row(ROW_REG, REG_CENTER_X, 5);
    add_row(ROW_REG, REG_CENTER_Y, 3);
    add_row(ROW_REG, REG_EFFECT_RADIUS, 3);
    add_row(ROW_STORE, 10, 2, 24'h0F0F0F);
    add_row(ROW_FETCH_KNOWN, 10, 2, 24'h0F0F0F);
    // Narrow the frame: a store past its edge is dropped, reads past it give black.
    add_row(ROW_REG, REG_IMAGE_WIDTH, 8);
    add_row(ROW_STORE, 10, 2, 24'hF0F0F0);
    add_row(ROW_FETCH_KNOWN, 10, 2, 24'h000000);
    add_row(ROW_FETCH_KNOWN, 3, 8, 24'h000000);
    add_row(ROW_REG, REG_IMAGE_WIDTH, 16);
    add_row(ROW_FETCH_KNOWN, 10, 2, 24'h0F0F0F);
    // Centre right of the frame: the source column saturates.
    add_row(ROW_REG, REG_CENTER_X, 20);
    add_row(ROW_REG, REG_EFFECT_RADIUS, 10);
    add_row(ROW_FETCH, 15, 3);
    add_row(ROW_FETCH, 12, 4);
    // Centre below the frame: the source row saturates.
    add_row(ROW_REG, REG_CENTER_Y, 10);
    add_row(ROW_REG, REG_CENTER_X, 5);
    add_row(ROW_FETCH, 5, 6);
    // Zero radius passes every pixel through.
    add_row(ROW_REG, REG_EFFECT_RADIUS, 0);
    add_row(ROW_FETCH_KNOWN, 10, 2, 24'h0F0F0F);
    // Smallest frame.
    add_row(ROW_REG, REG_IMAGE_WIDTH, 1);
    add_row(ROW_REG, REG_IMAGE_HEIGHT, 1);
    add_row(ROW_REG, REG_CENTER_X, 0);
    add_row(ROW_REG, REG_CENTER_Y, 0);
    add_row(ROW_STORE, 0, 0, 24'h010203);
    add_row(ROW_FETCH_KNOWN, 0, 0, 24'h010203);
    add_row(ROW_FETCH_KNOWN, 1, 0, 24'h000000);
    add_row(ROW_REG, REG_EFFECT_RADIUS, 72);
    add_row(ROW_FETCH_KNOWN, 0, 0, 24'h010203);
    // Full frame with the centre on its top right corner.
    add_row(ROW_REG, REG_IMAGE_WIDTH, 256);
    add_row(ROW_REG, REG_IMAGE_HEIGHT, 256);
    add_row(ROW_REG, REG_CENTER_X, 255);
    add_row(ROW_FETCH, 255, 0);
    add_row(ROW_FETCH, 200, 40);
    add_row(ROW_FETCH_KNOWN, 255, 255, 24'h000000);

    foreach (plan[i]) begin
      req_no_idle = ($urandom_range(0, 3) == 0);
      rsp_no_idle = ($urandom_range(0, 3) == 0);
      case (plan[i].kind)
        ROW_REG: begin
          drain_block();
          write_reg(plan[i].a[CFG_IDX_W-1:0], plan[i].b[CFG_DATA_W-1:0]);
        end
        ROW_STORE: send_request(REQ_WRITE, plan[i].a[7:0], plan[i].b[7:0], plan[i].pix, 1'b0);
        ROW_FETCH: fetch(plan[i].a, plan[i].b);
        default: send_request(REQ_READ, plan[i].a[7:0], plan[i].b[7:0], plan[i].pix, 1'b1);
      endcase
    end

    // Random phases: new settings each time, then a mix of stores and fetches
    // around the bulge, with some noise outside the frame.
    for (int ph = 0; ph < N_PHASES; ph++) begin : phase
      int w, h, cx, cy, r, x, y;
      case (ph)
        0: begin
          w = 256;
          h = 256;
        end
        1: begin
          w = 1;
          h = 1;
        end
        2: begin
          w = 256;
          h = $urandom_range(1, 4);
        end
        default: begin
          w = pick_dim();
          h = pick_dim();
        end
      endcase
      if ($urandom_range(0, 6) != 0) begin
        cx = $urandom_range(0, w - 1);
        cy = $urandom_range(0, h - 1);
      end else begin
        cx = $urandom_range(0, 255);
        cy = $urandom_range(0, 255);
      end
      r = (ph == 0) ? 72 : pick_radius(w, h);
      drain_block();
      write_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
      write_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
      write_reg(REG_CENTER_X, cx[CFG_DATA_W-1:0]);
      write_reg(REG_CENTER_Y, cy[CFG_DATA_W-1:0]);
      write_reg(REG_EFFECT_RADIUS, r[CFG_DATA_W-1:0]);
      req_no_idle = ($urandom_range(0, 3) == 0);
      rsp_no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        x = pick_coord(w, cx, r);
        y = pick_coord(h, cy, r);
        if ($urandom_range(0, 9) < 4)
          send_request(REQ_WRITE, x[7:0], y[7:0], PIX_W'($urandom), 1'b0);
        else
          fetch(x, y);
      end
    end

    // Drop valid, let every response come back, then let the tail run out.
    req_bus.valid <= 1'b0;
    while (warped_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
